FILE: rtl/core/pfe_pkg.sv
package pfe_pkg;

    localparam int COLUMNS = 128;
    localparam int PAGES   = 8;
    localparam int ROWS    = PAGES * 8;

    localparam int CMD_W    = 2;
    localparam int COLUMN_W = 7;
    localparam int ROW_W    = 6;
    localparam int PAGE_W   = 3;
    localparam int BYTE_W   = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_POINT   = 2'd1,
        CMD_PATTERN = 2'd2,
        CMD_READ    = 2'd3
    } t_cmd;

    // one column of the display, all pages stacked, bit 0 is the top row
    typedef logic [ROWS-1:0] t_line;

    typedef struct packed {
        logic load;    // capture the incoming word and start the line read
        logic finish;  // merge, write back and load the output register
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;  // output register can take a result this cycle
    } t_dp_status;

endpackage

FILE: rtl/core/pfe_ctrl.sv
module pfe_ctrl
    import pfe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    output t_dp_cmd    o_dp_cmd,
    input  t_dp_status i_dp_status
);

    typedef enum logic {
        ST_IDLE,
        ST_MODIFY
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;
    logic   n_busy;

    assign o_stall         = r_busy;
    assign o_dp_cmd.load   = (r_state == ST_IDLE) && i_valid;
    assign o_dp_cmd.finish = (r_state == ST_MODIFY) && i_dp_status.out_free;

    always_comb begin
        n_state = r_state;
        n_busy  = r_busy;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_MODIFY;
                    n_busy  = 1'b1;
                end
            end
            ST_MODIFY: begin
                // hold here while the previous result is still stalled
                if (i_dp_status.out_free) begin
                    n_state = ST_IDLE;
                    n_busy  = 1'b0;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

endmodule

FILE: rtl/core/pfe_datapath.sv
module pfe_datapath
    import pfe_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_dp_cmd,
    output t_dp_status          o_dp_status,
    input  logic [CMD_W-1:0]    i_cmd,
    input  logic [COLUMN_W-1:0] i_column,
    input  logic [ROW_W-1:0]    i_row,
    input  logic [PAGE_W-1:0]   i_page,
    input  logic                i_pixel_on,
    input  logic [BYTE_W-1:0]   i_pattern,
    input  logic                i_polarity,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output logic [BYTE_W-1:0]   o_read_data
);

    t_line r_mem [COLUMNS];
    logic [COLUMNS-1:0] r_line_valid;

    t_line               r_rd_line;
    logic                r_rd_valid;
    t_cmd                r_cmd;
    logic [COLUMN_W-1:0] r_column;
    logic [ROW_W-1:0]    r_row;
    logic [PAGE_W-1:0]   r_page;
    logic                r_pixel_on;
    logic [BYTE_W-1:0]   r_pattern;
    logic                r_polarity;

    logic                r_out_valid;
    logic [BYTE_W-1:0]   r_out_data;

    t_line             cur_line;
    t_line             mask;
    t_line             bits;
    t_line             merged;
    t_line             page_shifted;
    logic              col_ok;
    logic              row_ok;
    logic              page_ok;
    logic              do_write;
    logic [BYTE_W-1:0] pat_eff;
    logic [BYTE_W-1:0] result;

    assign o_dp_status.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid          = r_out_valid;
    assign o_read_data          = r_out_data;

    // a column never written since the last clear reads as all dark
    assign cur_line = r_rd_valid ? r_rd_line : '0;

    assign col_ok  = ({1'b0, r_column} < (COLUMN_W + 1)'(COLUMNS));
    assign row_ok  = ({1'b0, r_row} < (ROW_W + 1)'(ROWS));
    assign page_ok = ({1'b0, r_page} < (PAGE_W + 1)'(PAGES));
    assign pat_eff = r_polarity ? r_pattern : ~r_pattern;

    // shift the addressed page down so its byte sits in bits 7:0
    assign page_shifted = cur_line >> {r_page, 3'b000};

    always_comb begin
        mask     = '0;
        bits     = '0;
        do_write = 1'b0;
        result   = '0;
        unique case (r_cmd)
            CMD_CLEAR: begin
                result = '0;
            end
            CMD_POINT: begin
                mask     = ROWS'(1) << r_row;
                bits     = r_pixel_on ? mask : '0;
                do_write = col_ok && row_ok;
            end
            CMD_PATTERN: begin
                mask     = ROWS'({BYTE_W{1'b1}}) << r_row;
                bits     = ROWS'(pat_eff) << r_row;
                do_write = col_ok;
            end
            CMD_READ: begin
                result = (col_ok && page_ok) ? page_shifted[BYTE_W-1:0] : '0;
            end
            default: begin
                result = '0;
            end
        endcase
    end

    assign merged = (cur_line & ~mask) | (bits & mask);

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_rd_line  <= r_mem[i_column];
            r_cmd      <= t_cmd'(i_cmd);
            r_column   <= i_column;
            r_row      <= i_row;
            r_page     <= i_page;
            r_pixel_on <= i_pixel_on;
            r_pattern  <= i_pattern;
            r_polarity <= i_polarity;
        end
        if (i_dp_cmd.finish && do_write) begin
            r_mem[r_column] <= merged;
        end
        if (i_dp_cmd.finish) begin
            r_out_data <= result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_valid <= '0;
            r_rd_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_dp_cmd.load) begin
                r_rd_valid <= r_line_valid[i_column];
            end
            if (i_dp_cmd.finish && (r_cmd == CMD_CLEAR)) begin
                r_line_valid <= '0;
            end else if (i_dp_cmd.finish && do_write) begin
                r_line_valid[r_column] <= 1'b1;
            end
            if (i_dp_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

FILE: rtl/core/page_framebuffer_pixel_engine.sv
// Monochrome 128 x 64 framebuffer kept as one 64-bit line per column, page p in
// bits 8p+7:8p, bit 0 topmost. Each word is a command: clear, draw point, write
// an 8-pixel vertical pattern (may straddle two pages) or read one page byte;
// every word gives one result word, read_data, which is zero except for a read.
// Each word is a read-modify-write of the column memory: the line is read,
// then merged, written back and loaded into the output register, which waits
// while that register is full and stalled; o_stall is high meanwhile. Clear
// only drops the per-column valid flags; reset clears them too, so the store
// is usable at once. A new word is taken while a result still waits on i_stall.
module page_framebuffer_pixel_engine
    import pfe_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [CMD_W-1:0]    i_cmd,
    input  logic [COLUMN_W-1:0] i_column,
    input  logic [ROW_W-1:0]    i_row,
    input  logic [PAGE_W-1:0]   i_page,
    input  logic                i_pixel_on,
    input  logic [BYTE_W-1:0]   i_pattern,
    input  logic                i_polarity,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [BYTE_W-1:0]   o_read_data
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    pfe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .o_dp_cmd    (dp_cmd),
        .i_dp_status (dp_status)
    );

    pfe_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dp_cmd    (dp_cmd),
        .o_dp_status (dp_status),
        .i_cmd       (i_cmd),
        .i_column    (i_column),
        .i_row       (i_row),
        .i_page      (i_page),
        .i_pixel_on  (i_pixel_on),
        .i_pattern   (i_pattern),
        .i_polarity  (i_polarity),
        .i_out_stall (i_stall),
        .o_out_valid (o_valid),
        .o_read_data (o_read_data)
    );

endmodule

FILE: verif/pfe_frame_checker.sv
module pfe_frame_checker
    import pfe_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  logic [CMD_W-1:0]    i_cmd,
    input  logic [COLUMN_W-1:0] i_column,
    input  logic [ROW_W-1:0]    i_row,
    input  logic [PAGE_W-1:0]   i_page,
    input  logic                i_pixel_on,
    input  logic [BYTE_W-1:0]   i_pattern,
    input  logic                i_polarity,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  logic [BYTE_W-1:0]   i_read_data,
    output int                  o_fail_count,
    output int                  o_pending
);

    logic [BYTE_W-1:0] frame_mirror [COLUMNS][PAGES];
    logic [BYTE_W-1:0] read_bytes_due [$];
    int                fail_count = 0;
    int                pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    function automatic void put_pixel(int col, int r, logic lit);
        if (col >= COLUMNS || r >= ROWS) return;
        frame_mirror[COLUMN_W'(col)][PAGE_W'(r >> 3)][3'(r & 7)] = lit;
    endfunction

    // applies one command word to the mirror and returns the byte it reads back
    function automatic logic [BYTE_W-1:0] frame_update(
        t_cmd                cmd,
        logic [COLUMN_W-1:0] col,
        logic [ROW_W-1:0]    row,
        logic [PAGE_W-1:0]   page,
        logic                pixel_on,
        logic [BYTE_W-1:0]   pattern,
        logic                polarity
    );
        logic [BYTE_W-1:0] rd;
        rd = '0;
        case (cmd)
            CMD_CLEAR: begin
                foreach (frame_mirror[c, p]) frame_mirror[c][p] = '0;
            end
            CMD_POINT: begin
                put_pixel(int'(col), int'(row), pixel_on);
            end
            CMD_PATTERN: begin
                // pixels below the last row fall off, the rest still land
                for (int m = 0; m < 8; m++)
                    put_pixel(int'(col), int'(row) + m,
                              polarity ? pattern[m] : ~pattern[m]);
            end
            default: begin
                if (int'(col) < COLUMNS && int'(page) < PAGES)
                    rd = frame_mirror[col][page];
            end
        endcase
        return rd;
    endfunction

    always @(posedge i_clk) begin
        logic [BYTE_W-1:0] due;
        if (!i_rst_n) begin
            foreach (frame_mirror[c, p]) frame_mirror[c][p] = '0;
            read_bytes_due.delete();
        end else begin
            // retire the result first so a word taken this edge never matches it
            if (i_out_valid && !i_out_stall) begin
                if (read_bytes_due.size() == 0) begin
                    fail_count++;
                    $error("unexpected result word, read_data %0h", i_read_data);
                end else begin
                    due = read_bytes_due.pop_front();
                    if (i_read_data !== due) begin
                        fail_count++;
                        $error("read_data mismatch: expected %0h, actual %0h",
                               due, i_read_data);
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                read_bytes_due.push_back(frame_update(t_cmd'(i_cmd), i_column, i_row,
                                                      i_page, i_pixel_on, i_pattern,
                                                      i_polarity));
        end
        pending_count = read_bytes_due.size();
    end

endmodule

FILE: verif/tb_page_framebuffer_pixel_engine.sv
module tb_page_framebuffer_pixel_engine;
    import pfe_pkg::*;

    logic                i_clk;
    logic                i_rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [CMD_W-1:0]    cmd;
    logic [COLUMN_W-1:0] column;
    logic [ROW_W-1:0]    row;
    logic [PAGE_W-1:0]   page;
    logic                pixel_on;
    logic [BYTE_W-1:0]   pattern;
    logic                polarity;
    logic                out_valid;
    logic                out_stall;
    logic [BYTE_W-1:0]   read_data;
    int                  fail_count;
    int                  pending;
    bit                  tx_quiet;
    bit                  rx_quiet;

    page_framebuffer_pixel_engine u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_valid),
        .o_stall     (in_stall),
        .i_cmd       (cmd),
        .i_column    (column),
        .i_row       (row),
        .i_page      (page),
        .i_pixel_on  (pixel_on),
        .i_pattern   (pattern),
        .i_polarity  (polarity),
        .o_valid     (out_valid),
        .i_stall     (out_stall),
        .o_read_data (read_data)
    );

    pfe_frame_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_cmd        (cmd),
        .i_column     (column),
        .i_row        (row),
        .i_page       (page),
        .i_pixel_on   (pixel_on),
        .i_pattern    (pattern),
        .i_polarity   (polarity),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_read_data  (read_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_word(t_cmd c, logic [COLUMN_W-1:0] col, logic [ROW_W-1:0] r,
                             logic [PAGE_W-1:0] pg, logic on, logic [BYTE_W-1:0] pat,
                             logic pol);
        int gap;
        cmd      <= c;
        column   <= col;
        row      <= r;
        page     <= pg;
        pixel_on <= on;
        pattern  <= pat;
        polarity <= pol;
        in_valid <= 1'b1;
        do @(posedge i_clk); while (in_stall);
        gap = tx_quiet ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // receiver back-pressure
    initial begin
        int n;
        out_stall <= 1'b0;
        forever begin
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            n = rx_quiet ? 0 : pick_gap();
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial begin
        t_cmd                c;
        logic [COLUMN_W-1:0] col;
        logic [ROW_W-1:0]    r;
        int                  sel;
        i_rst_n  <= 1'b0;
        in_valid <= 1'b0;
        cmd      <= CMD_CLEAR;
        column   <= '0;
        row      <= '0;
        page     <= '0;
        pixel_on <= 1'b0;
        pattern  <= '0;
        polarity <= 1'b0;
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // store must read back empty after reset
        send_word(CMD_READ,    7'd0,   6'd0,  3'd0, 1'b0, 8'h00, 1'b1);
        send_word(CMD_READ,    7'd127, 6'd63, 3'd7, 1'b1, 8'hFF, 1'b0);
        send_word(CMD_POINT,   7'd0,   6'd0,  3'd0, 1'b1, 8'h00, 1'b0);
        send_word(CMD_POINT,   7'd127, 6'd63, 3'd7, 1'b1, 8'hFF, 1'b1);
        send_word(CMD_READ,    7'd0,   6'd0,  3'd0, 1'b0, 8'h00, 1'b0);
        send_word(CMD_READ,    7'd127, 6'd0,  3'd7, 1'b0, 8'h00, 1'b0);
        send_word(CMD_PATTERN, 7'd5,   6'd0,  3'd0, 1'b0, 8'hFF, 1'b1);
        send_word(CMD_READ,    7'd5,   6'd0,  3'd0, 1'b0, 8'h00, 1'b0);
        // inverted pattern straddling pages 0 and 1
        send_word(CMD_PATTERN, 7'd5,   6'd4,  3'd0, 1'b0, 8'h0F, 1'b0);
        send_word(CMD_READ,    7'd5,   6'd0,  3'd0, 1'b0, 8'h00, 1'b0);
        send_word(CMD_READ,    7'd5,   6'd0,  3'd1, 1'b0, 8'h00, 1'b0);
        // pattern running off the bottom edge
        send_word(CMD_PATTERN, 7'd127, 6'd60, 3'd0, 1'b0, 8'hFF, 1'b1);
        send_word(CMD_READ,    7'd127, 6'd0,  3'd7, 1'b0, 8'h00, 1'b0);
        send_word(CMD_PATTERN, 7'd127, 6'd63, 3'd0, 1'b0, 8'h00, 1'b0);
        send_word(CMD_READ,    7'd127, 6'd0,  3'd7, 1'b0, 8'h00, 1'b0);
        send_word(CMD_POINT,   7'd127, 6'd63, 3'd0, 1'b0, 8'h00, 1'b0);
        send_word(CMD_READ,    7'd127, 6'd0,  3'd7, 1'b0, 8'h00, 1'b0);
        send_word(CMD_POINT,   7'd0,   6'd0,  3'd0, 1'b0, 8'h00, 1'b0);
        send_word(CMD_READ,    7'd0,   6'd0,  3'd0, 1'b0, 8'h00, 1'b0);
        send_word(CMD_PATTERN, 7'd64,  6'd32, 3'd0, 1'b0, 8'hA5, 1'b1);
        send_word(CMD_READ,    7'd64,  6'd0,  3'd4, 1'b0, 8'h00, 1'b0);
        send_word(CMD_CLEAR,   7'd64,  6'd32, 3'd4, 1'b1, 8'h5A, 1'b1);
        send_word(CMD_READ,    7'd5,   6'd0,  3'd0, 1'b0, 8'h00, 1'b0);
        send_word(CMD_READ,    7'd64,  6'd0,  3'd4, 1'b0, 8'h00, 1'b0);
        send_word(CMD_READ,    7'd127, 6'd0,  3'd7, 1'b0, 8'h00, 1'b0);

        for (int k = 0; k < 1150; k++) begin
            if (k % 150 == 0) begin
                tx_quiet = ($urandom_range(0, 3) == 0);
                rx_quiet = ($urandom_range(0, 3) == 0);
            end
            sel = $urandom_range(0, 99);
            if (sel < 2)       c = CMD_CLEAR;
            else if (sel < 35) c = CMD_POINT;
            else if (sel < 65) c = CMD_PATTERN;
            else               c = CMD_READ;
            // keep half the traffic on a few edge columns so reads hit drawn bytes
            if ($urandom_range(0, 1))
                col = COLUMN_W'($urandom_range(0, 127));
            else if ($urandom_range(0, 1))
                col = COLUMN_W'($urandom_range(0, 3));
            else
                col = COLUMN_W'($urandom_range(124, 127));
            r = ROW_W'(($urandom_range(0, 3) == 0) ? $urandom_range(56, 63)
                                                  : $urandom_range(0, 63));
            send_word(c, col, r, PAGE_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                      BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
        in_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #20000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
